// File: sv/rrts_pkg.sv
// Shared types, codes and constants of the round-robin task scheduler.
`default_nettype none

package rrts_pkg;

    // Default size of the task table.
    localparam int TASKS_DEFAULT = 16;

    // Width of a task number on the ports.
    localparam int TASK_ID_W = 8;

    // Per-task flag bits.
    localparam int FLAG_W = 4;
    localparam logic [FLAG_W-1:0] FL_NONE  = 4'b0000;
    localparam logic [FLAG_W-1:0] FL_READY = 4'b0001;
    localparam logic [FLAG_W-1:0] FL_WAIT  = 4'b0010;
    localparam logic [FLAG_W-1:0] FL_SUSP  = 4'b0100;
    localparam logic [FLAG_W-1:0] FL_DORM  = 4'b1000;

    // Operation codes.
    typedef enum logic [3:0] {
        OP_CREATE  = 4'd0,
        OP_START   = 4'd1,
        OP_BEGIN   = 4'd2,
        OP_ROTATE  = 4'd3,
        OP_SUSPEND = 4'd4,
        OP_RESUME  = 4'd5,
        OP_RELEASE = 4'd6,
        OP_WAITBEG = 4'd7,
        OP_WAITEND = 4'd8,
        OP_EXIT    = 4'd9,
        OP_QUERY   = 4'd10,
        OP_DIS     = 4'd11,
        OP_ENA     = 4'd12
    } rrts_op_t;

    // Status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADID    = 3'd1,
        ST_NOEXIST  = 3'd2,
        ST_OBJ      = 3'd3,
        ST_NOTREADY = 3'd4,
        ST_NORUN    = 3'd5
    } rrts_status_t;

    // Request payload.
    typedef struct packed {
        logic [3:0]           operation;
        logic [TASK_ID_W-1:0] task_id;
        logic                 self_select;
    } rrts_req_t;

    // Result payload.
    typedef struct packed {
        logic [2:0]           status;
        logic [TASK_ID_W-1:0] current_task;
        logic                 switched;
        logic [TASK_ID_W-1:0] previous_task;
        logic [FLAG_W-1:0]    task_flags;
    } rrts_rsp_t;

endpackage

`default_nettype wire

// File: sv/rrts_table.sv
// Task flag table: one synchronous memory with per-entry valid bits.
`default_nettype none

module rrts_table
    import rrts_pkg::*;
#(
    parameter int TASKS = TASKS_DEFAULT,
    localparam int IDW = (TASKS > 1) ? $clog2(TASKS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [IDW-1:0]    rd_addr,
    output logic      [FLAG_W-1:0] rd_flags,
    input  wire logic              wr_en,
    input  wire logic [IDW-1:0]    wr_addr,
    input  wire logic [FLAG_W-1:0] wr_data
);

    logic [FLAG_W-1:0] mem [TASKS];
    logic [TASKS-1:0]  vld_reg;
    logic [FLAG_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits make entries never written read as zero after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_flags = rd_vld_reg ? rd_data_reg : FL_NONE;

endmodule

`default_nettype wire

// File: sv/round_robin_task_scheduler_top.sv
// Top level of the round-robin task scheduler: request decode, dispatcher and result register.
//
//   Channel | Ports                      | Direction | Payload
//   --------+----------------------------+-----------+-----------
//   request | s_valid, s_ready, s_data   | in        | rrts_req_t
//   result  | m_valid, m_ready, m_data   | out       | rrts_rsp_t
//
// A request is taken in IDLE, its table entry is read on the accept edge and
// evaluated in the next cycle, in EVAL; the result is registered in DONE.
// A request that rotates adds a scan of one table entry per cycle through the
// single memory read port, in state SCAN, before the result is registered.
// Reset clears the valid bits of the table at once; no clearing pass is needed.
// A stalled result holds the output register; a new request may be accepted
// meanwhile, and its result waits until the register is free.
`default_nettype none

module round_robin_task_scheduler_top
    import rrts_pkg::*;
#(
    parameter int TASKS = TASKS_DEFAULT
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire rrts_req_t s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output rrts_rsp_t      m_data
);

    localparam int IDW   = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CNT_W = IDW + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         op_reg;
    logic [IDW-1:0]     tgt_reg;
    logic               bad_reg;
    logic [IDW-1:0]     prev_reg;
    logic [2:0]         status_reg;
    logic               moved_reg;
    logic [FLAG_W-1:0]  qflags_reg;
    logic [IDW-1:0]     running_reg;
    logic               started_reg;
    logic               disabled_reg;
    logic [IDW-1:0]     iss_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               pend_reg;
    logic [IDW-1:0]     chk_reg;
    logic               m_valid_reg;
    rrts_rsp_t          m_data_reg;

    logic               s_accept;
    logic               in_uses_id;
    logic               in_id_ok;
    logic               in_on_running;
    logic [IDW-1:0]     in_tgt;
    logic               rd_en;
    logic [IDW-1:0]     rd_addr;
    logic [FLAG_W-1:0]  rd_flags;
    logic               wr_en;
    logic [IDW-1:0]     wr_addr;
    logic [FLAG_W-1:0]  wr_data;
    logic [2:0]         ev_status;
    logic               ev_rot;
    logic               ev_begin;
    logic [FLAG_W-1:0]  ev_qflags;
    logic               rot_go;
    logic               scan_hit;
    logic               scan_end;
    logic [IDW-1:0]     iss_wrap;
    logic               out_free;
    logic               keep_norun;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Request decode: which entry to read and whether the task number is checked.
    always_comb begin
        in_id_ok      = ({1'b0, s_data.task_id} < 9'(TASKS));
        in_uses_id    = ((s_data.operation <= OP_RELEASE) && (s_data.operation != OP_ROTATE))
                        || ((s_data.operation == OP_QUERY) && !s_data.self_select);
        in_on_running = (s_data.operation == OP_WAITBEG) || (s_data.operation == OP_WAITEND)
                        || (s_data.operation == OP_EXIT)
                        || ((s_data.operation == OP_QUERY) && s_data.self_select);
        in_tgt        = in_on_running ? running_reg : s_data.task_id[IDW-1:0];
    end

    // Round-robin scan: the candidate read last cycle is checked now.
    assign iss_wrap   = (iss_reg == IDW'(TASKS - 1)) ? '0 : iss_reg + 1'b1;
    assign scan_hit   = pend_reg && ((rd_flags & FL_SUSP) == FL_NONE)
                        && ((rd_flags & (FL_READY | FL_WAIT)) != FL_NONE);
    assign scan_end   = (cnt_reg == CNT_W'(TASKS));
    assign keep_norun = (op_reg == OP_ROTATE) || (op_reg == OP_EXIT);

    // Memory read port.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = in_tgt;
        if (s_accept) begin
            rd_en = 1'b1;
        end else if ((state_reg == S_SCAN) && !scan_hit && !scan_end) begin
            rd_en   = 1'b1;
            rd_addr = iss_wrap;
        end
    end

    // Operation evaluation on the entry read at accept.
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = tgt_reg;
        wr_data   = rd_flags;
        ev_status = ST_OK;
        ev_rot    = 1'b0;
        ev_begin  = 1'b0;
        ev_qflags = FL_NONE;
        if (bad_reg) begin
            ev_status = ST_BADID;
        end else begin
            case (op_reg)
                OP_CREATE: begin
                    wr_en   = 1'b1;
                    wr_data = FL_DORM;
                end
                OP_START: begin
                    wr_en   = 1'b1;
                    wr_data = FL_READY;
                end
                OP_BEGIN: begin
                    if (rd_flags != FL_READY) begin
                        ev_status = ST_NOTREADY;
                    end else begin
                        ev_begin = 1'b1;
                    end
                end
                OP_ROTATE: begin
                    ev_rot = 1'b1;
                end
                OP_SUSPEND: begin
                    if (rd_flags == FL_NONE) begin
                        ev_status = ST_NOEXIST;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = rd_flags | FL_SUSP;
                        ev_rot  = (tgt_reg == running_reg);
                    end
                end
                OP_RESUME: begin
                    if (rd_flags == FL_NONE) begin
                        ev_status = ST_NOEXIST;
                    end else if ((rd_flags & (FL_WAIT | FL_SUSP)) == FL_NONE) begin
                        ev_status = ST_OBJ;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = rd_flags & ~FL_SUSP;
                        ev_rot  = 1'b1;
                    end
                end
                OP_RELEASE: begin
                    if (rd_flags == FL_NONE) begin
                        ev_status = ST_NOEXIST;
                    end else if ((rd_flags & FL_WAIT) == FL_NONE) begin
                        ev_status = ST_OBJ;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = rd_flags & ~FL_WAIT;
                    end
                end
                OP_WAITBEG: begin
                    wr_en   = 1'b1;
                    wr_data = FL_WAIT;
                end
                OP_WAITEND: begin
                    wr_en   = 1'b1;
                    wr_data = (rd_flags & ~FL_WAIT) | FL_READY;
                end
                OP_EXIT: begin
                    wr_en   = 1'b1;
                    wr_data = FL_DORM;
                    ev_rot  = 1'b1;
                end
                OP_QUERY: begin
                    ev_qflags = rd_flags;
                end
                default: begin
                end
            endcase
        end
        wr_en  = wr_en && (state_reg == S_EVAL);
        rot_go = ev_rot && started_reg && !disabled_reg;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = rot_go ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (scan_hit || scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: sequencer, scheduler registers and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            running_reg  <= '0;
            started_reg  <= 1'b0;
            disabled_reg <= 1'b0;
            pend_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            // The output register fills in DONE and empties when its result is taken.
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                end
                S_EVAL: begin
                    if (!bad_reg) begin
                        if (ev_begin) begin
                            started_reg <= 1'b1;
                            running_reg <= tgt_reg;
                        end
                        if (op_reg == OP_DIS) begin
                            disabled_reg <= 1'b1;
                        end
                        if (op_reg == OP_ENA) begin
                            disabled_reg <= 1'b0;
                        end
                    end
                    cnt_reg  <= '0;
                    pend_reg <= 1'b0;
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        running_reg <= chk_reg;
                    end else if (!scan_end) begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end
                end
                S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Request and result payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= s_data.operation;
            tgt_reg  <= in_tgt;
            bad_reg  <= in_uses_id && !in_id_ok;
            prev_reg <= running_reg;
        end
        if (state_reg == S_EVAL) begin
            status_reg <= ev_status;
            moved_reg  <= ev_begin;
            qflags_reg <= ev_qflags;
            iss_reg    <= running_reg;
        end
        if (state_reg == S_SCAN) begin
            if (scan_hit) begin
                moved_reg <= (chk_reg != running_reg);
            end else if (scan_end) begin
                status_reg <= keep_norun ? ST_NORUN : ST_OK;
            end else begin
                iss_reg <= iss_wrap;
                chk_reg <= iss_wrap;
            end
        end
        if ((state_reg == S_DONE) && out_free) begin
            m_data_reg.status        <= status_reg;
            m_data_reg.current_task  <= TASK_ID_W'(running_reg);
            m_data_reg.switched      <= moved_reg;
            m_data_reg.previous_task <= TASK_ID_W'(prev_reg);
            m_data_reg.task_flags    <= qflags_reg;
        end
    end

    rrts_table #(
        .TASKS (TASKS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_flags (rd_flags),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

endmodule

`default_nettype wire
